FILE: rtl/sbts_pkg.sv
// ----------------------------------------------------------------------------
// sbts_pkg: shared types and constants of the sRGB bilinear texture sampler
// word layouts, register indexes, controller states and the sRGB decode table
// ----------------------------------------------------------------------------
package sbts_pkg;

    localparam int CFG_SIDE_W   = 10;
    localparam int CFG_STRIDE_W = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_TEX_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEX_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEXEL_STRIDE = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam int ADDR_IN_W = 18;
    localparam int BYTE_W    = 8;
    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int LIN_W     = 17;

    // input word: byte_addr, byte_value, coord_u, coord_v from bit 0 up
    localparam int TD_BYTE_ADDR_LSB  = 0;
    localparam int TD_BYTE_VALUE_LSB = 18;
    localparam int TD_COORD_U_LSB    = 26;
    localparam int TD_COORD_V_LSB    = 58;
    localparam int S_TDATA_W         = 96;

    // result word: red, green, blue from bit 0 up
    localparam int M_TDATA_W = 56;

    localparam logic [1:0] LAST_TAP = 2'd3;
    localparam logic [1:0] LAST_CH  = 2'd2;

    localparam int BIG_W = 320;

    typedef struct packed {
        logic [CFG_SIDE_W-1:0]   tex_width;
        logic [CFG_SIDE_W-1:0]   tex_height;
        logic [CFG_STRIDE_W-1:0] texel_stride;
    } sbts_cfg_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SCALE,
        F_ROW,
        F_TEXEL,
        F_REDUCE,
        F_PUSH
    } sbts_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_DRAIN,
        B_DONE
    } sbts_back_state_t;

    // for c>10 the largest y with (2y-1)^5*269025^12<=2^85*(1000c+14025)^12
    function automatic logic [LIN_W-1:0] decode_entry(input int unsigned code,
                                                       input logic [BIG_W-1:0] dpow);
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        int unsigned      n;
        int               k;
        int               it;
        if (code <= 10)
        begin
            return LIN_W'((655360 * code + 16473) / 32946);
        end
        n = 1000 * code + 14025;
        rhs = BIG_W'(1);
        for (k = 0; k < 12; k++)
        begin
            rhs = rhs * BIG_W'(n);
        end
        rhs = rhs << 85;
        lo = 0;
        hi = 65536;
        for (it = 0; it < 17; it++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                lhs = dpow;
                for (k = 0; k < 5; k++)
                begin
                    lhs = lhs * BIG_W'(2 * mid - 1);
                end
                if (lhs <= rhs)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
        end
        return LIN_W'(lo);
    endfunction

    function automatic logic [256*LIN_W-1:0] decode_table();
        logic [256*LIN_W-1:0] tbl;
        logic [BIG_W-1:0]     dpow;
        int                   k;
        int                   c;
        dpow = BIG_W'(1);
        for (k = 0; k < 12; k++)
        begin
            dpow = dpow * BIG_W'(269025);
        end
        tbl = '0;
        for (c = 0; c < 256; c++)
        begin
            tbl[c*LIN_W +: LIN_W] = decode_entry(int'(c), dpow);
        end
        return tbl;
    endfunction

    localparam logic [256*LIN_W-1:0] DECODE_LUT = decode_table();

    function automatic logic [LIN_W-1:0] srgb_to_linear(input logic [BYTE_W-1:0] code);
        return DECODE_LUT[code*LIN_W +: LIN_W];
    endfunction

endpackage

FILE: rtl/sbts_queue.sv
// ----------------------------------------------------------------------------
// sbts_queue: two-entry job queue
// decouples the address front end from the store and blend back end
// ----------------------------------------------------------------------------
module sbts_queue
#(
    parameter int W = 1
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/sbts_front.sv
// ----------------------------------------------------------------------------
// sbts_front: word intake and address generation
// scales the wrapped coordinates, forms the four texel indexes and reduces
// every store address modulo the store size by reciprocal multiplication,
// quotient registered first, remainder from that registered quotient next
// ----------------------------------------------------------------------------
module sbts_front
    import sbts_pkg::*;
#(
    parameter int TEX_BYTES = 262144,
    parameter int MAX_SIDE  = 512
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbts_cfg_t             cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic [4*$clog2(TEX_BYTES)+2*FRAC_W:0] push_job
);

    localparam int AW      = $clog2(TEX_BYTES);
    localparam int RW      = AW + 1;
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int CMP_W   = (CFG_SIDE_W > SIDE_W) ? CFG_SIDE_W : SIDE_W;
    localparam int PU_W    = SIDE_W + FRAC_W;
    localparam int IDX_W   = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int PROD_W  = IDX_W + 2;
    localparam int VAL_W   = (PROD_W > ADDR_IN_W) ? PROD_W : ADDR_IN_W;
    // quotient by ceil(2^RCP_S / size), exact for every value below 2^VAL_W
    localparam int RCP_S   = VAL_W + AW;
    localparam int RCP_W   = VAL_W + 2;
    localparam int MUL_W   = VAL_W + RCP_W;
    localparam longint unsigned RCP_M =
        ((64'd1 << RCP_S) + 64'(TEX_BYTES) - 64'd1) / 64'(TEX_BYTES);
    localparam int N_ITER  = 2;
    localparam int IT_W    = 1;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] s);
        logic [CMP_W-1:0] sc;
        sc = CMP_W'(s);
        if (sc == '0)
        begin
            return SIDE_W'(1);
        end
        if (sc > CMP_W'(MAX_SIDE))
        begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(sc);
    endfunction

    sbts_front_state_t state_reg;
    sbts_front_state_t state_next;

    logic                  is_sample_reg;
    logic                  is_sample_next;
    logic [FRAC_W-1:0]     fu_reg;
    logic [FRAC_W-1:0]     fu_next;
    logic [FRAC_W-1:0]     fv_reg;
    logic [FRAC_W-1:0]     fv_next;
    logic [BYTE_W-1:0]     data_reg;
    logic [BYTE_W-1:0]     data_next;
    logic [PU_W-1:0]       pu_reg;
    logic [PU_W-1:0]       pu_next;
    logic [PU_W-1:0]       pv_reg;
    logic [PU_W-1:0]       pv_next;
    logic [IDX_W-1:0]      row0_reg;
    logic [IDX_W-1:0]      row0_next;
    logic [IDX_W-1:0]      row1_reg;
    logic [IDX_W-1:0]      row1_next;
    logic [VAL_W-1:0]      val_reg [4];
    logic [VAL_W-1:0]      val_next [4];
    logic [VAL_W-1:0]      quo_reg [4];
    logic [VAL_W-1:0]      quo_next [4];
    logic [RW-1:0]         rem_reg [4];
    logic [RW-1:0]         rem_next [4];
    logic [IT_W-1:0]       iter_reg;
    logic [IT_W-1:0]       iter_next;

    logic                  accept;
    logic                  reduce_done;
    logic [SIDE_W-1:0]     w_side;
    logic [SIDE_W-1:0]     h_side;
    logic [SIDE_W-1:0]     wm1;
    logic [SIDE_W-1:0]     hm1;
    logic                  stride4;
    logic [SIDE_W-1:0]     x0;
    logic [SIDE_W-1:0]     x1;
    logic [SIDE_W-1:0]     y0;
    logic [SIDE_W-1:0]     y1;
    logic [IDX_W-1:0]      tex_idx [4];
    logic [PROD_W-1:0]     tex_byte [4];
    logic [VAL_W-1:0]      quo_step [4];
    logic [RW-1:0]         rem_step [4];
    logic [FRAC_W-1:0]     dx_field;

    assign w_side  = clamp_side(cfg.tex_width);
    assign h_side  = clamp_side(cfg.tex_height);
    assign wm1     = w_side - SIDE_W'(1);
    assign hm1     = h_side - SIDE_W'(1);
    assign stride4 = (cfg.texel_stride >= 3'd4);

    assign x0 = pu_reg[PU_W-1:FRAC_W];
    assign y0 = pv_reg[PU_W-1:FRAC_W];
    assign x1 = (x0 == wm1) ? x0 : x0 + SIDE_W'(1);
    assign y1 = (y0 == hm1) ? y0 : y0 + SIDE_W'(1);

    assign accept      = s_tvalid && s_tready;
    assign reduce_done = (iter_reg == IT_W'(N_ITER - 1));

    // texel order: (x0,y0) (x0,y1) (x1,y0) (x1,y1)
    always_comb
    begin
        tex_idx[0] = row0_reg + IDX_W'(x0);
        tex_idx[1] = row1_reg + IDX_W'(x0);
        tex_idx[2] = row0_reg + IDX_W'(x1);
        tex_idx[3] = row1_reg + IDX_W'(x1);
        for (int j = 0; j < 4; j++)
        begin
            if (stride4)
            begin
                tex_byte[j] = PROD_W'(tex_idx[j]) << 2;
            end
            else
            begin
                tex_byte[j] = PROD_W'(tex_idx[j]) + (PROD_W'(tex_idx[j]) << 1);
            end
        end
    end

    // quotient from the value, remainder from the quotient of the cycle before
    always_comb
    begin
        logic [MUL_W-1:0] qprod;
        logic [VAL_W-1:0] diff;
        for (int j = 0; j < 4; j++)
        begin
            qprod       = MUL_W'(val_reg[j]) * MUL_W'(RCP_M);
            quo_step[j] = VAL_W'(qprod >> RCP_S);
            diff        = val_reg[j] - VAL_W'(quo_reg[j] * VAL_W'(TEX_BYTES));
            rem_step[j] = RW'(diff);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_tuser == OP_SAMPLE) ? F_SCALE : F_REDUCE;
                end
            end
            F_SCALE:  state_next = F_ROW;
            F_ROW:    state_next = F_TEXEL;
            F_TEXEL:  state_next = F_REDUCE;
            F_REDUCE:
            begin
                if (reduce_done)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:  state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            F_IDLE:   s_tready = 1'b1;
            F_PUSH:   push_valid = 1'b1;
            default:
            begin
                s_tready   = 1'b0;
                push_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        is_sample_next = is_sample_reg;
        fu_next        = fu_reg;
        fv_next        = fv_reg;
        data_next      = data_reg;
        pu_next        = pu_reg;
        pv_next        = pv_reg;
        row0_next      = row0_reg;
        row1_next      = row1_reg;
        val_next       = val_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        iter_next      = iter_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    is_sample_next = (s_tuser == OP_SAMPLE);
                    fu_next   = s_tdata[TD_COORD_U_LSB +: FRAC_W];
                    fv_next   = s_tdata[TD_COORD_V_LSB +: FRAC_W];
                    data_next = s_tdata[TD_BYTE_VALUE_LSB +: BYTE_W];
                    for (int j = 0; j < 4; j++)
                    begin
                        val_next[j] = '0;
                        rem_next[j] = '0;
                    end
                    val_next[0] = VAL_W'(s_tdata[TD_BYTE_ADDR_LSB +: ADDR_IN_W]);
                    iter_next   = '0;
                end
            end
            F_SCALE:
            begin
                pu_next = PU_W'(wm1) * PU_W'(fu_reg);
                pv_next = PU_W'(hm1) * PU_W'(fv_reg);
            end
            F_ROW:
            begin
                row0_next = IDX_W'(y0) * IDX_W'(w_side);
                row1_next = IDX_W'(y1) * IDX_W'(w_side);
            end
            F_TEXEL:
            begin
                for (int j = 0; j < 4; j++)
                begin
                    val_next[j] = VAL_W'(tex_byte[j]);
                    rem_next[j] = '0;
                end
                iter_next = '0;
            end
            F_REDUCE:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                iter_next = iter_reg + IT_W'(1);
            end
            default:
            begin
                iter_next = iter_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_sample_reg <= is_sample_next;
        fu_reg        <= fu_next;
        fv_reg        <= fv_next;
        data_reg      <= data_next;
        pu_reg        <= pu_next;
        pv_reg        <= pv_next;
        row0_reg      <= row0_next;
        row1_reg      <= row1_next;
        val_reg       <= val_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        iter_reg      <= iter_next;
    end

    // job: kind, four store bases (write address in the first), dx or byte, dy
    assign dx_field = is_sample_reg ? pu_reg[FRAC_W-1:0] : FRAC_W'(data_reg);

    always_comb
    begin
        push_job[0] = is_sample_reg;
        for (int j = 0; j < 4; j++)
        begin
            push_job[1 + j*AW +: AW] = rem_reg[j][AW-1:0];
        end
        push_job[1 + 4*AW +: FRAC_W]          = dx_field;
        push_job[1 + 4*AW + FRAC_W +: FRAC_W] = pv_reg[FRAC_W-1:0];
    end

endmodule

FILE: rtl/sbts_back.sv
// ----------------------------------------------------------------------------
// sbts_back: texel store and bilinear blend
// holds the byte store, reads twelve bytes per sample through its single
// port, decodes them to linear and accumulates the weighted sums
// ----------------------------------------------------------------------------
module sbts_back
    import sbts_pkg::*;
#(
    parameter int TEX_BYTES = 262144
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   job_valid,
    output logic                                   job_ready,
    input  logic [4*$clog2(TEX_BYTES)+2*FRAC_W:0]  job,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [LIN_W-1:0]                       red_linear,
    output logic [LIN_W-1:0]                       green_linear,
    output logic [LIN_W-1:0]                       blue_linear
);

    localparam int AW    = $clog2(TEX_BYTES);
    localparam int SUM_W = AW + 1;
    localparam int WT_W  = 2 * FRAC_W + 1;
    localparam int ACC_W = WT_W + FRAC_W;

    sbts_back_state_t state_reg;
    sbts_back_state_t state_next;

    logic [BYTE_W-1:0] store_mem [TEX_BYTES];
    logic [BYTE_W-1:0] rd_reg;

    logic [AW-1:0]     base_reg [4];
    logic [FRAC_W-1:0] dx_reg;
    logic [FRAC_W-1:0] dy_reg;
    logic [WT_W-1:0]   wt_reg [4];
    logic [1:0]        k_reg;
    logic [1:0]        k_next;
    logic [1:0]        ch_reg;
    logic [1:0]        ch_next;

    logic              s1_valid_reg;
    logic [1:0]        s1_k_reg;
    logic [1:0]        s1_ch_reg;
    logic              s2_valid_reg;
    logic [1:0]        s2_k_reg;
    logic [1:0]        s2_ch_reg;
    logic [LIN_W-1:0]  lin_reg;
    logic              s3_valid_reg;
    logic [1:0]        s3_ch_reg;
    logic [ACC_W-1:0]  prod_reg;
    logic [ACC_W-1:0]  acc_reg [3];

    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [LIN_W-1:0]  red_reg;
    logic [LIN_W-1:0]  green_reg;
    logic [LIN_W-1:0]  blue_reg;

    logic              job_sample;
    logic              take_sample;
    logic              issue;
    logic              last_fetch;
    logic              drained;
    logic              load_out;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [AW-1:0]     fetch_addr;
    logic [SUM_W-1:0]  fetch_sum;
    logic [LIN_W-1:0]  inv_dx;
    logic [LIN_W-1:0]  inv_dy;
    logic [LIN_W-1:0]  ext_dx;
    logic [LIN_W-1:0]  ext_dy;

    assign job_sample  = (job[0] == OP_SAMPLE);
    assign take_sample = (state_reg == B_IDLE) && job_valid && job_sample;
    assign mem_we      = (state_reg == B_IDLE) && job_valid && !job_sample;
    assign issue       = (state_reg == B_FETCH);
    assign last_fetch  = (k_reg == LAST_TAP) && (ch_reg == LAST_CH);
    assign drained     = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign load_out    = (state_reg == B_DONE) && (!m_tvalid_reg || m_tready);

    // channel byte of a texel, wrapped once into the store
    always_comb
    begin
        fetch_sum = {1'b0, base_reg[k_reg]} + SUM_W'(ch_reg);
        if (fetch_sum >= SUM_W'(TEX_BYTES))
        begin
            fetch_sum = fetch_sum - SUM_W'(TEX_BYTES);
        end
        fetch_addr = fetch_sum[AW-1:0];
    end

    assign mem_addr = issue ? fetch_addr : job[1 +: AW];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= job[1 + 4*AW +: BYTE_W];
        end
        rd_reg <= store_mem[mem_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (take_sample)
                begin
                    state_next = B_FETCH;
                end
            end
            B_FETCH:
            begin
                if (last_fetch)
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                if (drained)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready = 1'b0;
        unique case (state_reg)
            B_IDLE:  job_ready = 1'b1;
            default: job_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        k_next  = k_reg;
        ch_next = ch_reg;
        if (take_sample)
        begin
            k_next  = '0;
            ch_next = '0;
        end
        else if (issue)
        begin
            if (ch_reg == LAST_CH)
            begin
                ch_next = '0;
                k_next  = k_reg + 2'd1;
            end
            else
            begin
                ch_next = ch_reg + 2'd1;
            end
        end
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            k_reg        <= '0;
            ch_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            ch_reg       <= ch_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign ext_dx = LIN_W'(dx_reg);
    assign ext_dy = LIN_W'(dy_reg);
    assign inv_dx = LIN_W'(1 << FRAC_W) - ext_dx;
    assign inv_dy = LIN_W'(1 << FRAC_W) - ext_dy;

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            for (int j = 0; j < 4; j++)
            begin
                base_reg[j] <= job[1 + j*AW +: AW];
            end
            dx_reg <= job[1 + 4*AW +: FRAC_W];
            dy_reg <= job[1 + 4*AW + FRAC_W +: FRAC_W];
        end
        // weights in texel order (x0,y0) (x0,y1) (x1,y0) (x1,y1)
        wt_reg[0] <= WT_W'(inv_dx) * WT_W'(inv_dy);
        wt_reg[1] <= WT_W'(inv_dx) * WT_W'(ext_dy);
        wt_reg[2] <= WT_W'(ext_dx) * WT_W'(inv_dy);
        wt_reg[3] <= WT_W'(ext_dx) * WT_W'(ext_dy);
        s1_k_reg  <= k_reg;
        s1_ch_reg <= ch_reg;
        lin_reg   <= srgb_to_linear(rd_reg);
        s2_k_reg  <= s1_k_reg;
        s2_ch_reg <= s1_ch_reg;
        prod_reg  <= ACC_W'(wt_reg[s2_k_reg]) * ACC_W'(lin_reg);
        s3_ch_reg <= s2_ch_reg;
        for (int c = 0; c < 3; c++)
        begin
            if (take_sample)
            begin
                acc_reg[c] <= '0;
            end
            else if (s3_valid_reg && (s3_ch_reg == 2'(c)))
            begin
                acc_reg[c] <= acc_reg[c] + prod_reg;
            end
        end
        if (load_out)
        begin
            red_reg   <= acc_reg[0][2*FRAC_W +: LIN_W];
            green_reg <= acc_reg[1][2*FRAC_W +: LIN_W];
            blue_reg  <= acc_reg[2][2*FRAC_W +: LIN_W];
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign red_linear   = red_reg;
    assign green_linear = green_reg;
    assign blue_linear  = blue_reg;

endmodule

FILE: rtl/srgb_bilinear_texture_sample.sv
// path: a sample word passes the front end states, the job queue, the byte reads and
//   the blend pipeline, waiting while the back end is busy or the result side is not ready
// flow: the front end takes one word at a time; the back end holds each sample for twelve
//   byte reads through the single store port and for the blend pipeline
// reset: sets control state and config registers; datapath registers and the texel store are not cleared
// ----------------------------------------------------------------------------
// srgb_bilinear_texture_sample: sRGB bilinear texture sampler
// write words fill a byte texture store, sample words return linear rgb
// ----------------------------------------------------------------------------
module srgb_bilinear_texture_sample
    import sbts_pkg::*;
#(
    parameter int TEX_BYTES = 262144,
    parameter int MAX_SIDE  = 512
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // byte_addr, byte_value, coord_u, coord_v
    input  logic                   s_tuser,   // opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // red_linear, green_linear, blue_linear
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW    = $clog2(TEX_BYTES);
    localparam int JOB_W = 4 * AW + 2 * FRAC_W + 1;

    sbts_cfg_t        cfg_reg;
    sbts_cfg_t        cfg_next;
    logic             push_valid;
    logic             push_ready;
    logic [JOB_W-1:0] push_job;
    logic             job_valid;
    logic             job_ready;
    logic [JOB_W-1:0] job;
    logic [LIN_W-1:0] red_linear;
    logic [LIN_W-1:0] green_linear;
    logic [LIN_W-1:0] blue_linear;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TEX_WIDTH:    cfg_next.tex_width    = cfg_data[CFG_SIDE_W-1:0];
                REG_TEX_HEIGHT:   cfg_next.tex_height   = cfg_data[CFG_SIDE_W-1:0];
                REG_TEXEL_STRIDE: cfg_next.texel_stride = cfg_data[CFG_STRIDE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tex_width    <= CFG_SIDE_W'(1);
            cfg_reg.tex_height   <= CFG_SIDE_W'(1);
            cfg_reg.texel_stride <= CFG_STRIDE_W'(3);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sbts_front #(
        .TEX_BYTES (TEX_BYTES),
        .MAX_SIDE  (MAX_SIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    sbts_queue #(
        .W (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (job_valid),
        .pop_ready  (job_ready),
        .pop_data   (job)
    );

    sbts_back #(
        .TEX_BYTES (TEX_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .red_linear   (red_linear),
        .green_linear (green_linear),
        .blue_linear  (blue_linear)
    );

    assign m_tdata = {(M_TDATA_W - 3*LIN_W)'(0), blue_linear, green_linear, red_linear};

`ifndef SYNTHESIS
    // the front end works on one word at a time
    a_front_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("front end took a word while busy");

    // a sample holds the back end for its fetch sequence
    a_back_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready && (job[0] == OP_SAMPLE) |=> !job_ready)
        else $error("back end took a job during a sample");

    // a store write completes in the cycle it is popped
    a_back_free_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready && (job[0] == OP_WRITE) |=> job_ready)
        else $error("back end stalled after a store write");
`endif

endmodule
